// ----- src/lpd_pkg.sv -----
// lpd_pkg: shared types and constants of the length-prefixed deframer
`default_nettype none
package lpd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned WordW = 32;
	localparam int unsigned IdxW  = 3;

	// header byte positions
	localparam logic [IdxW-1:0] LenFirst = 3'd0;
	localparam logic [IdxW-1:0] IdFirst  = 3'd4;
	localparam logic [IdxW-1:0] HdrLast  = 3'd7;

	localparam int unsigned OutDataW = 72;
	localparam int unsigned OutUserW = 2;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] payload_byte;
		logic [WordW-1:0] message_id;
		logic [WordW-1:0] message_length;
		logic             first_of_message;
		logic             last_of_message;
		logic             empty_message;
	} res_t;

endpackage
`default_nettype wire

// ----- src/length_prefixed_deframer_top.sv -----
// length_prefixed_deframer_top: byte stream in, tagged payload bytes out
//
//  channel  dir  tdata                                   tlast            tuser
//  s_axis   in   [7:0] data_byte                         -                -
//  m_axis   out  [7:0] payload_byte, [39:8] message_id,  last_of_message  [0] first_of_message
//                [71:40] message_length                                   [1] empty_message
//
// one byte is taken per cycle while ready is high; a result appears in the cycle after the byte that causes it
// header bytes give no result, except the eighth of a zero-length message (empty marker)
// every payload byte gives one result
// ready follows the output register: high while it is empty or being drained
// arst_n clears the header counter, accumulators and the output valid
`default_nettype none
module length_prefixed_deframer_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // data_byte
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// payload_byte, message_id, message_length
	output logic [lpd_pkg::OutDataW-1:0]       m_axis_tdata,
	output logic                               m_axis_tlast,
	// first_of_message, empty_message
	output logic [lpd_pkg::OutUserW-1:0]       m_axis_tuser
);
	import lpd_pkg::*;

	res_t res;
	logic can_load;
	logic take;

	assign s_axis_tready = can_load;
	assign take          = s_axis_tvalid && can_load;

	lpd_hdr u_hdr (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_axis_tdata),
		.res       (res)
	);

	lpd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast),
		.m_tuser  (m_axis_tuser)
	);

endmodule
`default_nettype wire

// ----- src/lpd_hdr.sv -----
// lpd_hdr: header gathering, payload count and result generation
`default_nettype none
module lpd_hdr (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  take,
	input  wire logic [lpd_pkg::ByteW-1:0] data_byte,
	output lpd_pkg::res_t              res
);
	import lpd_pkg::*;

	logic [IdxW-1:0]  hdr_idx_q;
	logic [WordW-1:0] len_acc_q;
	logic [WordW-1:0] id_acc_q;
	logic [WordW-1:0] remaining_q;
	logic             in_payload_q;
	logic             at_first_q;

	logic [WordW-1:0] byte_ext;
	logic [WordW-1:0] byte_shifted;
	logic [WordW-1:0] len_next;
	logic [WordW-1:0] id_next;
	logic             pay_last;

	assign byte_ext     = {{(WordW-ByteW){1'b0}}, data_byte};
	assign byte_shifted = byte_ext << {hdr_idx_q[1:0], 3'b000};
	assign pay_last     = (remaining_q[WordW-1:1] == '0);

	always_comb begin
		len_next = len_acc_q;
		id_next  = id_acc_q;
		if (hdr_idx_q == LenFirst) begin
			len_next = byte_ext;
		end else if (hdr_idx_q < IdFirst) begin
			len_next = len_acc_q | byte_shifted;
		end else if (hdr_idx_q == IdFirst) begin
			id_next = byte_ext;
		end else begin
			id_next = id_acc_q | byte_shifted;
		end
	end

	always_comb begin
		res                  = '0;
		res.message_id       = id_acc_q;
		res.message_length   = len_acc_q;
		res.payload_byte     = data_byte;
		res.first_of_message = at_first_q;
		res.last_of_message  = pay_last;
		if (in_payload_q) begin
			res.valid = take;
		end else begin
			// empty marker on the last header byte of a zero-length message
			res.message_id       = id_next;
			res.payload_byte     = '0;
			res.first_of_message = 1'b1;
			res.last_of_message  = 1'b1;
			res.empty_message    = 1'b1;
			res.valid            = take && (hdr_idx_q == HdrLast) && (len_acc_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q    <= '0;
			len_acc_q    <= '0;
			id_acc_q     <= '0;
			remaining_q  <= '0;
			in_payload_q <= 1'b0;
			at_first_q   <= 1'b0;
		end else if (take) begin
			if (in_payload_q) begin
				at_first_q <= 1'b0;
				if (pay_last) begin
					remaining_q  <= '0;
					in_payload_q <= 1'b0;
				end else begin
					remaining_q <= remaining_q - 1'b1;
				end
			end else begin
				len_acc_q <= len_next;
				id_acc_q  <= id_next;
				if (hdr_idx_q == HdrLast) begin
					hdr_idx_q <= '0;
					if (len_acc_q != '0) begin
						remaining_q  <= len_acc_q;
						in_payload_q <= 1'b1;
						at_first_q   <= 1'b1;
					end
				end else begin
					hdr_idx_q <= hdr_idx_q + 1'b1;
				end
			end
		end
	end

	a_idx_idle_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (hdr_idx_q == LenFirst))
		else $error("header index moved during payload");

	a_remaining_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (remaining_q != '0))
		else $error("payload active with no bytes left");

	a_payload_start: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !in_payload_q && hdr_idx_q == HdrLast && len_acc_q != '0)
		|=> (in_payload_q && at_first_q && remaining_q == $past(len_acc_q)))
		else $error("payload did not start after header");

	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.empty_message) |-> (!in_payload_q && hdr_idx_q == HdrLast))
		else $error("empty marker outside header end");

endmodule
`default_nettype wire

// ----- src/lpd_out.sv -----
// lpd_out: result register toward the master-side stream
`default_nettype none
module lpd_out (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  lpd_pkg::res_t                     res,
	output logic                              can_load,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [lpd_pkg::OutDataW-1:0]      m_tdata,
	output logic                              m_tlast,
	output logic [lpd_pkg::OutUserW-1:0]      m_tuser
);
	import lpd_pkg::*;

	logic             valid_q;
	logic [ByteW-1:0] byte_q;
	logic [WordW-1:0] id_q;
	logic [WordW-1:0] len_q;
	logic             first_q;
	logic             last_q;
	logic             empty_q;

	// register frees up in the same cycle its transaction completes
	assign can_load = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && res.valid) begin
			byte_q  <= res.payload_byte;
			id_q    <= res.message_id;
			len_q   <= res.message_length;
			first_q <= res.first_of_message;
			last_q  <= res.last_of_message;
			empty_q <= res.empty_message;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {len_q, id_q, byte_q};
	assign m_tlast  = last_q;
	assign m_tuser  = {empty_q, first_q};

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !m_tready) |=> (valid_q && $stable(id_q) && $stable(byte_q)))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- sim/tb_length_prefixed_deframer_top.sv -----
// testbench: drives a byte stream into the deframer and checks every tagged payload byte
module tb_length_prefixed_deframer_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lpd_pkg::*;

	localparam int CycleLimit = 200000;

	// tracks header and payload position and holds the payload bytes still owed
	class deframe_scoreboard;
		logic [IdxW-1:0]  hdr_pos;
		logic [WordW-1:0] len_acc;
		logic [WordW-1:0] id_acc;
		logic [WordW-1:0] remaining;
		bit               in_payload;
		bit               first_pending;
		res_t             expected_beats[$];
		int               errors;

		function new();
			hdr_pos = LenFirst;
			len_acc = '0;
			id_acc = '0;
			remaining = '0;
			in_payload = 0;
			first_pending = 0;
			errors = 0;
		endfunction

		function void note_byte(logic [ByteW-1:0] b);
			res_t r;
			r.valid = 1'b1;
			r.message_id = id_acc;
			r.message_length = len_acc;
			if (in_payload) begin
				r.payload_byte = b;
				r.first_of_message = first_pending;
				r.last_of_message = (remaining <= 1);
				r.empty_message = 1'b0;
				expected_beats.push_back(r);
				first_pending = 0;
				remaining = remaining - 1;
				if (r.last_of_message) begin
					remaining = '0;
					in_payload = 0;
				end
				return;
			end
			// header bytes are little endian; the first byte of each word overwrites it
			if (hdr_pos < IdFirst) begin
				if (hdr_pos == LenFirst)
					len_acc = WordW'(b);
				else
					len_acc |= WordW'(b) << (8 * hdr_pos[1:0]);
			end else begin
				if (hdr_pos == IdFirst)
					id_acc = WordW'(b);
				else
					id_acc |= WordW'(b) << (8 * hdr_pos[1:0]);
			end
			if (hdr_pos == HdrLast) begin
				hdr_pos = LenFirst;
				if (len_acc == 0) begin
					r.payload_byte = '0;
					r.message_id = id_acc;
					r.message_length = len_acc;
					r.first_of_message = 1'b1;
					r.last_of_message = 1'b1;
					r.empty_message = 1'b1;
					expected_beats.push_back(r);
				end else begin
					remaining = len_acc;
					in_payload = 1;
					first_pending = 1;
				end
			end else begin
				hdr_pos = hdr_pos + 1'b1;
			end
		endfunction

		function void check_beat(logic [OutDataW-1:0] data, logic last, logic [OutUserW-1:0] user);
			res_t e;
			if (expected_beats.size() == 0) begin
				$error("unexpected output transaction: tdata %h", data);
				errors++;
				return;
			end
			e = expected_beats.pop_front();
			if (data[7:0] !== e.payload_byte) begin
				$error("payload_byte: expected %h, got %h", e.payload_byte, data[7:0]);
				errors++;
			end
			if (data[39:8] !== e.message_id) begin
				$error("message_id: expected %h, got %h", e.message_id, data[39:8]);
				errors++;
			end
			if (data[71:40] !== e.message_length) begin
				$error("message_length: expected %h, got %h", e.message_length, data[71:40]);
				errors++;
			end
			if (user[0] !== e.first_of_message) begin
				$error("first_of_message: expected %b, got %b", e.first_of_message, user[0]);
				errors++;
			end
			if (last !== e.last_of_message) begin
				$error("last_of_message: expected %b, got %b", e.last_of_message, last);
				errors++;
			end
			if (user[1] !== e.empty_message) begin
				$error("empty_message: expected %b, got %b", e.empty_message, user[1]);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata;   // data_byte
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OutDataW-1:0] m_axis_tdata;   // payload_byte, message_id, message_length
	logic                m_axis_tlast;   // last_of_message
	logic [OutUserW-1:0] m_axis_tuser;   // first_of_message, empty_message

	deframe_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold;
	int bytes_sent;
	int cycle_count;

	length_prefixed_deframer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold = 0;
		bytes_sent = 0;
		cycle_count = 0;
		sb = new();
	end

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random back-pressure, plus a long hold-off when requested
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_header(input logic [31:0] len, input logic [31:0] id);
		for (int i = 0; i < 4; i++)
			send_byte(len[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			send_byte(id[8*i +: 8]);
	endtask

	task automatic send_payload(input int count);
		for (int i = 0; i < count; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		int unsigned len;
		int target;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, all-ones id
		send_header(32'd0, 32'hFFFF_FFFF);
		// single byte message, zero id
		send_header(32'd1, 32'd0);
		send_byte(8'hFF);
		// header restart after stale bits, payload bytes 00 and 5A
		send_header(32'd2, 32'h8000_0001);
		send_byte(8'h00);
		send_byte(8'h5A);

		target = bytes_sent;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 19;
					rx_idle_pct = 56;
				end
				1: begin
					tx_idle_pct = 56;
					rx_idle_pct = 19;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			target += 430;
			if (ph == 2) begin
				// receiver stalls while a long message keeps coming, filling the block
				rx_hold = 250;
				send_header(32'd300, $urandom());
				send_payload(300);
			end
			while (bytes_sent < target) begin
				len = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
				send_header(len, $urandom());
				send_payload(len);
			end
		end

		// largest length last: it swallows every byte that follows
		send_header(32'hFFFF_FFFF, $urandom());
		send_payload(60);
		s_axis_tvalid <= 1'b0;

		while (sb.expected_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
